// ----- rtl/iidl_pkg.sv -----
package iidl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int FIELD_W      = 7;

	localparam logic       CMD_INSERT = 1'b0;
	localparam logic       CMD_DELETE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic                      command;
		logic [FIELD_W-1:0]        position;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] positive_count;
		logic [FIELD_W-1:0] negative_count;
		logic [FIELD_W-1:0] zero_count;
	} rsp_t;

	// Shift command broadcast to every cell.
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [FIELD_W-1:0] pos;
		logic [DATA_W-1:0]  value;
	} cell_ctl_t;

	// Sign class of one element.
	typedef struct packed {
		logic pos;
		logic neg;
		logic zero;
	} cls_t;

endpackage

// ----- rtl/iidl_cell.sv -----
module iidl_cell #(
	parameter int INDEX = 0
) (
	input  logic                             clk,
	input  iidl_pkg::cell_ctl_t              ctl,
	input  logic [iidl_pkg::DATA_W-1:0]      left,
	input  logic [iidl_pkg::DATA_W-1:0]      right,
	output logic [iidl_pkg::DATA_W-1:0]      value,
	output iidl_pkg::cls_t                   cls
);

	logic [iidl_pkg::DATA_W-1:0] value_q;
	logic [31:0]                 pos_w;
	logic                        at_pos;
	logic                        above_pos;

	assign pos_w     = {{(32-iidl_pkg::FIELD_W){1'b0}}, ctl.pos};
	assign at_pos    = (32'(INDEX) == pos_w);
	assign above_pos = (32'(INDEX) > pos_w);

	// Insert: load at the gap, take the lower neighbor above it.
	// Delete: take the upper neighbor from the gap upward.
	always_ff @(posedge clk) begin
		if (ctl.ins && at_pos) begin
			value_q <= ctl.value;
		end else if (ctl.ins && above_pos) begin
			value_q <= left;
		end else if (ctl.del && (at_pos || above_pos)) begin
			value_q <= right;
		end
	end

	assign value    = value_q;
	assign cls.zero = at_pos && (value_q == '0);
	assign cls.neg  = at_pos && value_q[iidl_pkg::DATA_W-1];
	assign cls.pos  = at_pos && (value_q != '0) && !value_q[iidl_pkg::DATA_W-1];

endmodule

// ----- rtl/iidl_chain.sv -----
module iidl_chain #(
	parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  iidl_pkg::cell_ctl_t ctl,
	output iidl_pkg::cls_t      sel_cls
);

	logic [iidl_pkg::DATA_W-1:0] cell_val [CAPACITY];
	iidl_pkg::cls_t              cell_cls [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [iidl_pkg::DATA_W-1:0] left_w;
		logic [iidl_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_val[i-1];
		end

		if (i == CAPACITY-1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_val[i+1];
		end

		iidl_cell #(
			.INDEX(i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.left (left_w),
			.right(right_w),
			.value(cell_val[i]),
			.cls  (cell_cls[i])
		);
	end

	// At most one cell matches the position; merge their class flags.
	always_comb begin
		sel_cls = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_cls = sel_cls | cell_cls[i];
		end
	end

endmodule

// ----- rtl/indexed_insert_delete_list.sv -----
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   command, position, value
// rsp      out        rsp_valid/rsp_stall   status, length, sign counts
//
// One request is taken per cycle while req_stall is low; its response is
// registered and shows in the cycle after acceptance. All cells shift in the
// same cycle as the request. Reset clears the length and the sign counts;
// cell contents are left as they are and are only read below the length.
// req_stall is high only while a response is held and rsp_stall is high.
module indexed_insert_delete_list #(
	parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  iidl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output iidl_pkg::rsp_t  rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > iidl_pkg::FIELD_W) ? CNT_W : iidl_pkg::FIELD_W;

	logic [CMP_W-1:0]    len_q, npos_q, nneg_q, nzero_q;
	logic [CMP_W-1:0]    len_d, npos_d, nneg_d, nzero_d;
	logic [CMP_W-1:0]    pos_ext;
	logic                req_acc;
	logic [1:0]          status;
	logic                ins_ok, del_ok;
	logic                ins_pos, ins_neg, ins_zero;
	iidl_pkg::cell_ctl_t ctl;
	iidl_pkg::cls_t      sel_cls;
	logic                rsp_valid_q;
	iidl_pkg::rsp_t      rsp_q;

	// Hold the request only while the response register is full and stalled.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_acc   = req_valid && !req_stall;

	assign pos_ext = CMP_W'(req.position);

	// Range check comes before the full check on insert.
	always_comb begin
		status = iidl_pkg::STATUS_OK;
		if (req.command == iidl_pkg::CMD_INSERT) begin
			if (pos_ext > len_q) begin
				status = iidl_pkg::STATUS_BAD_INDEX;
			end else if (len_q == CMP_W'(CAPACITY)) begin
				status = iidl_pkg::STATUS_FULL;
			end
		end else begin
			if (pos_ext >= len_q) begin
				status = iidl_pkg::STATUS_BAD_INDEX;
			end
		end
	end

	assign ins_ok = req_acc && (req.command == iidl_pkg::CMD_INSERT)
		&& (status == iidl_pkg::STATUS_OK);
	assign del_ok = req_acc && (req.command == iidl_pkg::CMD_DELETE)
		&& (status == iidl_pkg::STATUS_OK);

	assign ctl.ins   = ins_ok;
	assign ctl.del   = del_ok;
	assign ctl.pos   = req.position;
	assign ctl.value = req.value;

	iidl_chain #(
		.CAPACITY(CAPACITY)
	) u_chain (
		.clk    (clk),
		.ctl    (ctl),
		.sel_cls(sel_cls)
	);

	// Class of the incoming value.
	assign ins_zero = (req.value == '0);
	assign ins_neg  = req.value[iidl_pkg::DATA_W-1];
	assign ins_pos  = !ins_zero && !ins_neg;

	// Advance the counts: add the inserted class, drop the deleted one.
	always_comb begin
		len_d   = len_q;
		npos_d  = npos_q;
		nneg_d  = nneg_q;
		nzero_d = nzero_q;
		if (ins_ok) begin
			len_d   = len_q + CMP_W'(1);
			npos_d  = npos_q + CMP_W'(ins_pos);
			nneg_d  = nneg_q + CMP_W'(ins_neg);
			nzero_d = nzero_q + CMP_W'(ins_zero);
		end else if (del_ok) begin
			len_d   = len_q - CMP_W'(1);
			npos_d  = npos_q - CMP_W'(sel_cls.pos);
			nneg_d  = nneg_q - CMP_W'(sel_cls.neg);
			nzero_d = nzero_q - CMP_W'(sel_cls.zero);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			npos_q  <= '0;
			nneg_q  <= '0;
			nzero_q <= '0;
		end else begin
			len_q   <= len_d;
			npos_q  <= npos_d;
			nneg_q  <= nneg_d;
			nzero_q <= nzero_d;
		end
	end

	// Response register: load on accept, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			rsp_q.status         <= status;
			rsp_q.length         <= len_d[iidl_pkg::FIELD_W-1:0];
			rsp_q.positive_count <= npos_d[iidl_pkg::FIELD_W-1:0];
			rsp_q.negative_count <= nneg_d[iidl_pkg::FIELD_W-1:0];
			rsp_q.zero_count     <= nzero_d[iidl_pkg::FIELD_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(npos_q + nneg_q + nzero_q) == len_q)
		else $error("sign counts do not add up to length");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CMP_W'(CAPACITY))
		else $error("length above capacity");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("accepted request gave no response");

	a_len_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!req_acc |=> $stable(len_q))
		else $error("length changed without a request");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ins_ok && del_ok))
		else $error("insert and delete at once");

endmodule
